### rtl/smlod_pkg.sv
// smlod_pkg: shared constants, register indexes and sequencer state type
// for the smooth level-of-detail selector
// no dependencies
package smlod_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int PAIR_COUNT = 3;
  localparam int EFF_MAX    = (MAX_LEVELS < PAIR_COUNT + 1) ? MAX_LEVELS : PAIR_COUNT + 1;

  localparam int LEVEL_W = 2;
  localparam int COUNT_W = 3;
  localparam int PAIR_W  = $clog2(PAIR_COUNT);
  localparam int DIST_W  = 24;
  localparam int TIME_W  = 16;
  localparam int RATE_W  = 16;
  localparam int PROD_W  = TIME_W + RATE_W;
  localparam int DEC_W   = PROD_W - 8;
  localparam int MIX_W   = 17;
  localparam int SWGT_W  = 18;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;

  localparam logic [MIX_W-1:0]  MIX_ONE = MIX_W'(65536);
  localparam logic [SWGT_W-1:0] MIX_TWO = SWGT_W'(131072);
  localparam logic [RATE_W-1:0] FADE_RATE_RESET = RATE_W'(256);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_ONE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_ONE   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_TWO   = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_TWO   = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_THREE = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER_THREE = CFG_INDEX_W'(6);
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_RATE   = CFG_INDEX_W'(7);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_FADE  = 6'b000100,
    ST_INNER = 6'b001000,
    ST_OUTER = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

### rtl/smooth_lod_selector.sv
// smooth_lod_selector: level-of-detail choice with hysteresis and timed cross-fade
// one request at a time; a fade tick steps through multiply, compare/subtract and
// hand-off, a level walk tests the inner and, if needed, the outer threshold of each
// threshold pair through the shared 24-bit comparator, plus hand-off
// a new request is taken only after the hand-off of the last one, which waits for out_ready
// reset (rst, synchronous): state cleared, level_count 1, thresholds 0, fade_rate 1.0
module smooth_lod_selector (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smlod_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smlod_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smlod_pkg::DIST_W-1:0]         lod_distance,
  input  logic [smlod_pkg::TIME_W-1:0]         time_step,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smlod_pkg::LEVEL_W-1:0]        primary_level,
  output logic [smlod_pkg::LEVEL_W-1:0]        secondary_level,
  output logic                                 secondary_shown,
  output logic [smlod_pkg::MIX_W-1:0]          mix_factor,
  output logic [smlod_pkg::MIX_W-1:0]          primary_weight,
  output logic [smlod_pkg::SWGT_W-1:0]         secondary_weight
);

  // configuration registers
  logic [smlod_pkg::COUNT_W-1:0] level_count;
  logic [smlod_pkg::DIST_W-1:0]  inner_thr [smlod_pkg::PAIR_COUNT];
  logic [smlod_pkg::DIST_W-1:0]  outer_thr [smlod_pkg::PAIR_COUNT];
  logic [smlod_pkg::RATE_W-1:0]  fade_rate;

  // sequencer and working registers
  smlod_pkg::state_t             state, state_next;
  logic [smlod_pkg::COUNT_W-1:0] cnt;
  logic [smlod_pkg::PAIR_W-1:0]  walk_idx, walk_idx_next;
  logic [smlod_pkg::DIST_W-1:0]  req_dist;
  logic [smlod_pkg::TIME_W-1:0]  tstep;
  logic [smlod_pkg::PROD_W-1:0]  prod;

  // selector state
  logic [smlod_pkg::LEVEL_W-1:0] cur_level, cur_level_next;
  logic [smlod_pkg::LEVEL_W-1:0] old_level, old_level_next;
  logic [smlod_pkg::MIX_W-1:0]   mix, mix_next;
  logic                          old_visible, old_visible_next;

  // shared comparator
  logic [smlod_pkg::DIST_W-1:0]  cmp_a, cmp_b;
  logic                          cmp_lt;

  logic [smlod_pkg::COUNT_W-1:0] eff_count;
  logic [smlod_pkg::COUNT_W-1:0] band_lo, band_hi, cur_ext, last_level;
  logic [smlod_pkg::LEVEL_W-1:0] new_level;
  logic                          new_valid;
  logic                          out_free;
  logic                          in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == smlod_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // level 0 acts as 1, anything above the pair limit saturates
  always_comb begin
    if (level_count == '0) begin
      eff_count = smlod_pkg::COUNT_W'(1);
    end else if (level_count > smlod_pkg::COUNT_W'(smlod_pkg::EFF_MAX)) begin
      eff_count = smlod_pkg::COUNT_W'(smlod_pkg::EFF_MAX);
    end else begin
      eff_count = level_count;
    end
  end

  // one comparator serves both the fade test and the threshold walk
  always_comb begin
    cmp_a = req_dist;
    cmp_b = inner_thr[walk_idx];
    case (state)
      smlod_pkg::ST_FADE: begin
        cmp_a = prod[smlod_pkg::PROD_W-1:8];
        cmp_b = smlod_pkg::DIST_W'(mix);
      end
      smlod_pkg::ST_OUTER: begin
        cmp_b = outer_thr[walk_idx];
      end
      default: begin
        cmp_b = inner_thr[walk_idx];
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  // hysteresis band [i, i+1] around the current level
  assign band_lo    = smlod_pkg::COUNT_W'(walk_idx);
  assign band_hi    = band_lo + smlod_pkg::COUNT_W'(1);
  assign cur_ext    = smlod_pkg::COUNT_W'(cur_level);
  assign last_level = cnt - smlod_pkg::COUNT_W'(1);

  // sequencer
  always_comb begin
    state_next       = state;
    walk_idx_next    = walk_idx;
    cur_level_next   = cur_level;
    old_level_next   = old_level;
    mix_next         = mix;
    old_visible_next = old_visible;
    new_level        = cur_level;
    new_valid        = 1'b0;

    case (state)
      smlod_pkg::ST_IDLE: begin
        if (in_fire) begin
          walk_idx_next = '0;
          if (eff_count <= smlod_pkg::COUNT_W'(1)) begin
            state_next = smlod_pkg::ST_DONE;
          end else if (mix != '0) begin
            state_next = smlod_pkg::ST_MUL;
          end else begin
            state_next = smlod_pkg::ST_INNER;
          end
        end
      end
      smlod_pkg::ST_MUL: begin
        state_next = smlod_pkg::ST_FADE;
      end
      smlod_pkg::ST_FADE: begin
        // decrement at or past the remaining mix ends the fade
        if (!cmp_lt) begin
          mix_next         = '0;
          old_visible_next = 1'b0;
        end else begin
          mix_next = mix - prod[8 +: smlod_pkg::MIX_W];
        end
        state_next = smlod_pkg::ST_DONE;
      end
      smlod_pkg::ST_INNER: begin
        if (cmp_lt) begin
          new_level  = smlod_pkg::LEVEL_W'(band_lo);
          new_valid  = 1'b1;
          state_next = smlod_pkg::ST_DONE;
        end else begin
          state_next = smlod_pkg::ST_OUTER;
        end
      end
      smlod_pkg::ST_OUTER: begin
        if (cmp_lt) begin
          if (cur_ext < band_lo) begin
            new_level = smlod_pkg::LEVEL_W'(band_lo);
          end else if (cur_ext > band_hi) begin
            new_level = smlod_pkg::LEVEL_W'(band_hi);
          end else begin
            new_level = cur_level;
          end
          new_valid  = 1'b1;
          state_next = smlod_pkg::ST_DONE;
        end else if (band_hi + smlod_pkg::COUNT_W'(1) >= cnt) begin
          // beyond all thresholds in use
          new_level  = smlod_pkg::LEVEL_W'(last_level);
          new_valid  = 1'b1;
          state_next = smlod_pkg::ST_DONE;
        end else begin
          walk_idx_next = walk_idx + smlod_pkg::PAIR_W'(1);
          state_next    = smlod_pkg::ST_INNER;
        end
      end
      smlod_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = smlod_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smlod_pkg::ST_IDLE;
      end
    endcase

    // a level change starts a fade
    if (new_valid && new_level != cur_level) begin
      old_level_next   = cur_level;
      cur_level_next   = new_level;
      mix_next         = smlod_pkg::MIX_ONE;
      old_visible_next = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= smlod_pkg::ST_IDLE;
      walk_idx    <= '0;
      cur_level   <= '0;
      old_level   <= '0;
      mix         <= '0;
      old_visible <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      walk_idx    <= walk_idx_next;
      cur_level   <= cur_level_next;
      old_level   <= old_level_next;
      mix         <= mix_next;
      old_visible <= old_visible_next;
      if (state == smlod_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= smlod_pkg::COUNT_W'(1);
      inner_thr   <= '{default: '0};
      outer_thr   <= '{default: '0};
      fade_rate   <= smlod_pkg::FADE_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        smlod_pkg::REG_LEVEL_COUNT: level_count  <= cfg_data[smlod_pkg::COUNT_W-1:0];
        smlod_pkg::REG_INNER_ONE:   inner_thr[0] <= cfg_data;
        smlod_pkg::REG_OUTER_ONE:   outer_thr[0] <= cfg_data;
        smlod_pkg::REG_INNER_TWO:   inner_thr[1] <= cfg_data;
        smlod_pkg::REG_OUTER_TWO:   outer_thr[1] <= cfg_data;
        smlod_pkg::REG_INNER_THREE: inner_thr[2] <= cfg_data;
        smlod_pkg::REG_OUTER_THREE: outer_thr[2] <= cfg_data;
        smlod_pkg::REG_FADE_RATE:   fade_rate    <= cfg_data[smlod_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request capture, product and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_dist <= lod_distance;
      tstep    <= time_step;
      cnt      <= eff_count;
    end
    if (state == smlod_pkg::ST_MUL) begin
      prod <= smlod_pkg::PROD_W'(tstep) * smlod_pkg::PROD_W'(fade_rate);
    end
    if (state == smlod_pkg::ST_DONE && out_free) begin
      primary_level    <= cur_level;
      secondary_level  <= old_level;
      secondary_shown  <= old_visible;
      mix_factor       <= mix;
      primary_weight   <= smlod_pkg::MIX_ONE - mix;
      secondary_weight <= smlod_pkg::MIX_TWO - smlod_pkg::SWGT_W'(mix);
    end
  end

  // mix never rises above 1.0
  assert property (@(posedge clk) disable iff (rst) mix <= smlod_pkg::MIX_ONE)
    else $error("mix above one");

  // the secondary level is shown exactly while a fade remains
  assert property (@(posedge clk) disable iff (rst) (mix != '0) == old_visible)
    else $error("secondary visibility out of step with mix");

  // the walk never looks past the last pair in use
  assert property (@(posedge clk) disable iff (rst)
    (state == smlod_pkg::ST_INNER || state == smlod_pkg::ST_OUTER) |->
      (smlod_pkg::COUNT_W'(walk_idx) + smlod_pkg::COUNT_W'(1) < cnt))
    else $error("walk index beyond level count");

  // an accepted request keeps the next one out in the cycle after it is taken
  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ready)
    else $error("request taken while busy");

  // the primary weight always agrees with the reported mix while a result is valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smlod_pkg::SWGT_W'(primary_weight) + smlod_pkg::SWGT_W'(mix_factor)
                   == smlod_pkg::SWGT_W'(smlod_pkg::MIX_ONE)))
    else $error("primary weight does not match mix");

endmodule
